// ===== src/srrw_pkg.sv =====
// Package for the selective-repeat receive window.
// Holds field widths, opcode and result codes, and the control structs
// shared by the controller, the datapath and the top level.
package srrw_pkg;

  localparam int WINDOW_SLOTS_DEF = 32;

  localparam int OP_W    = 2;
  localparam int SEQ_W   = 31;
  localparam int BASE_W  = 32;
  localparam int LEN_W   = 16;
  localparam int TAG_W   = 16;
  localparam int KIND_W  = 2;
  localparam int FREE_W  = 7;
  localparam int ENTRY_W = SEQ_W + LEN_W + TAG_W;

  // Input opcodes.
  localparam logic [OP_W-1:0] DATA_PACKET   = 2'd0;
  localparam logic [OP_W-1:0] DONE_NOTICE   = 2'd1;
  localparam logic [OP_W-1:0] CLOSE_REQUEST = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FINISH  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLOSED  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic drain;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic store_ok;
    logic head_full;
    logic next_full;
  } status_t;

endpackage

// ===== src/srrw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/srrw_ctrl.sv =====
// Controller for the receive window: accepts items and sequences the
// in-order drain after a store. Uses srrw_pkg for the command and status structs.
module srrw_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [srrw_pkg::OP_W-1:0]    opcode_i,
  input  srrw_pkg::status_t            status_i,
  output srrw_pkg::cmd_t               cmd_o,
  output logic                         busy_o
);

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  state_e state_q;
  logic   busy_q;

  always_comb begin
    cmd_o.accept = start_i && !busy_q;
    cmd_o.drain  = (state_q == ST_DRAIN) && status_i.head_full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i && (opcode_i == srrw_pkg::DATA_PACKET) && status_i.store_ok) begin
            state_q <= ST_DRAIN;
            busy_q  <= 1'b1;
          end
        end
        ST_DRAIN: begin
          // The run ends at the first empty slot after the head.
          if (!status_i.head_full || !status_i.next_full) begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o = busy_q;

endmodule

// ===== src/srrw_dpath.sv =====
// Datapath for the receive window: window checks, slot bookkeeping,
// slot RAM and result registers. Uses srrw_pkg and srrw_ram.
module srrw_dpath #(
  parameter int WINDOW_SLOTS = srrw_pkg::WINDOW_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  srrw_pkg::cmd_t                 cmd_i,
  output srrw_pkg::status_t              status_o,
  input  logic [srrw_pkg::OP_W-1:0]      opcode_i,
  input  logic [srrw_pkg::SEQ_W-1:0]     seq_i,
  input  logic [srrw_pkg::LEN_W-1:0]     length_i,
  input  logic [srrw_pkg::TAG_W-1:0]     payload_tag_i,
  output logic                           strobe_o,
  output logic [srrw_pkg::KIND_W-1:0]    kind_o,
  output logic [srrw_pkg::SEQ_W-1:0]     ack_seq_o,
  output logic [srrw_pkg::LEN_W-1:0]     out_length_o,
  output logic [srrw_pkg::TAG_W-1:0]     out_tag_o,
  output logic [srrw_pkg::FREE_W-1:0]    free_slots_o,
  output logic                           last_of_run_o
);

  localparam int IDX_W = $clog2(WINDOW_SLOTS);
  localparam int CNT_W = $clog2(WINDOW_SLOTS + 1);
  localparam logic [IDX_W:0]                 SLOTS_X = (IDX_W + 1)'(WINDOW_SLOTS);
  localparam logic [srrw_pkg::BASE_W-1:0]    SLOTS_B = srrw_pkg::BASE_W'(WINDOW_SLOTS);
  localparam logic [IDX_W-1:0]               LAST_IDX = IDX_W'(WINDOW_SLOTS - 1);
  localparam logic [CNT_W-1:0]               SLOTS_C = CNT_W'(WINDOW_SLOTS);

  logic [srrw_pkg::BASE_W-1:0] base_q, base_d;
  logic [IDX_W-1:0]            bidx_q, bidx_d;
  logic [WINDOW_SLOTS-1:0]     full_q, full_d;
  logic [CNT_W-1:0]            free_q, free_d;
  logic                        final_known_q, final_known_d;
  logic [srrw_pkg::SEQ_W-1:0]  final_seq_q, final_seq_d;
  logic                        closed_q, closed_d;
  logic                        valid_q, valid_d;
  logic [srrw_pkg::KIND_W-1:0] kind_q, kind_d;
  logic [srrw_pkg::FREE_W-1:0] fout_q, fout_d;
  logic                        last_q, last_d;

  logic [srrw_pkg::BASE_W-1:0] seq_ext;
  logic [srrw_pkg::BASE_W-1:0] diff;
  logic                        in_window;
  logic [IDX_W:0]              slot_sum;
  logic [IDX_W-1:0]            slot;
  logic [IDX_W-1:0]            next_idx;
  logic                        store_ok;
  logic                        finish_ok;
  logic                        ram_we;
  logic [srrw_pkg::ENTRY_W-1:0] ram_rdata;

  // The slot of an in-window item is the head slot plus its distance
  // from the base, wrapped once.
  always_comb begin
    seq_ext   = {1'b0, seq_i};
    diff      = seq_ext - base_q;
    in_window = (seq_ext >= base_q) && (diff < SLOTS_B);
    slot_sum  = {1'b0, bidx_q} + {1'b0, diff[IDX_W-1:0]};
    if (slot_sum >= SLOTS_X) begin
      slot = IDX_W'(slot_sum - SLOTS_X);
    end else begin
      slot = slot_sum[IDX_W-1:0];
    end
    next_idx  = (bidx_q == LAST_IDX) ? '0 : bidx_q + 1'b1;
    store_ok  = !closed_q && (opcode_i == srrw_pkg::DATA_PACKET) && in_window &&
                !full_q[slot];
    finish_ok = (base_q != '0) && (base_q > {1'b0, final_seq_q});
  end

  assign status_o.store_ok  = store_ok;
  assign status_o.head_full = full_q[bidx_q];
  assign status_o.next_full = full_q[next_idx];

  assign ram_we = cmd_i.accept && store_ok;

  always_comb begin
    base_d        = base_q;
    bidx_d        = bidx_q;
    full_d        = full_q;
    free_d        = free_q;
    final_known_d = final_known_q;
    final_seq_d   = final_seq_q;
    closed_d      = closed_q;
    valid_d       = 1'b0;
    kind_d        = kind_q;
    fout_d        = fout_q;
    last_d        = last_q;
    if (cmd_i.accept && !closed_q) begin
      case (opcode_i)
        srrw_pkg::DATA_PACKET: begin
          if (store_ok) begin
            full_d[slot] = 1'b1;
            free_d       = free_q - 1'b1;
          end
        end
        srrw_pkg::DONE_NOTICE: begin
          if (!final_known_q) begin
            final_known_d = 1'b1;
            final_seq_d   = seq_i;
          end else if (finish_ok) begin
            valid_d = 1'b1;
            kind_d  = srrw_pkg::KIND_FINISH;
            fout_d  = srrw_pkg::FREE_W'(free_q);
            last_d  = 1'b1;
          end
        end
        srrw_pkg::CLOSE_REQUEST: begin
          closed_d = 1'b1;
          valid_d  = 1'b1;
          kind_d   = srrw_pkg::KIND_CLOSED;
          fout_d   = srrw_pkg::FREE_W'(free_q);
          last_d   = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (cmd_i.drain) begin
      // Deliver the head slot; its RAM word appears with the result beat.
      full_d[bidx_q] = 1'b0;
      free_d         = free_q + 1'b1;
      base_d         = base_q + 1'b1;
      bidx_d         = next_idx;
      valid_d        = 1'b1;
      kind_d         = srrw_pkg::KIND_DELIVER;
      fout_d         = srrw_pkg::FREE_W'(free_q + 1'b1);
      last_d         = !full_q[next_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q        <= '0;
      bidx_q        <= '0;
      full_q        <= '0;
      free_q        <= SLOTS_C;
      final_known_q <= 1'b0;
      final_seq_q   <= '0;
      closed_q      <= 1'b0;
      valid_q       <= 1'b0;
    end else begin
      base_q        <= base_d;
      bidx_q        <= bidx_d;
      full_q        <= full_d;
      free_q        <= free_d;
      final_known_q <= final_known_d;
      final_seq_q   <= final_seq_d;
      closed_q      <= closed_d;
      valid_q       <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    fout_q <= fout_d;
    last_q <= last_d;
  end

  srrw_ram #(
    .WIDTH(srrw_pkg::ENTRY_W),
    .DEPTH(WINDOW_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot),
    .wdata_i({seq_i, length_i, payload_tag_i}),
    .re_i   (cmd_i.drain),
    .raddr_i(bidx_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    strobe_o      = valid_q;
    kind_o        = kind_q;
    free_slots_o  = fout_q;
    last_of_run_o = last_q;
    if (kind_q == srrw_pkg::KIND_DELIVER) begin
      ack_seq_o    = ram_rdata[srrw_pkg::ENTRY_W-1 -: srrw_pkg::SEQ_W];
      out_length_o = ram_rdata[srrw_pkg::TAG_W +: srrw_pkg::LEN_W];
      out_tag_o    = ram_rdata[srrw_pkg::TAG_W-1:0];
    end else begin
      ack_seq_o    = '0;
      out_length_o = '0;
      out_tag_o    = '0;
    end
  end

endmodule

// ===== src/selective_repeat_receive_window.sv =====
// Top level of the selective-repeat receive window.
// Instantiates srrw_ctrl and srrw_dpath; uses srrw_pkg.
//
//   Channel   Handshake                 Payload
//   input     start / busy              opcode, seq, length, payload_tag
//   result    strobe_o (one cycle)      kind, ack_seq, out_length, out_tag,
//                                       free_slots, last_of_run
//
// A stored data beat sends the controller to its drain state; busy holds the
// input off while the run drains at one result per cycle, the first result
// going through the state register, then the result and RAM read registers.
// Any other beat, dropped data included, needs no drain; done and close
// beats answer in the following cycle.
// Reset clears the window, the slot flags and all control state at once.
// Results cannot be held off; each one is valid for exactly one cycle.
module selective_repeat_receive_window #(
  parameter int WINDOW_SLOTS = srrw_pkg::WINDOW_SLOTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [srrw_pkg::OP_W-1:0]    opcode_i,
  input  logic [srrw_pkg::SEQ_W-1:0]   seq_i,
  input  logic [srrw_pkg::LEN_W-1:0]   length_i,
  input  logic [srrw_pkg::TAG_W-1:0]   payload_tag_i,
  output logic                         strobe_o,
  output logic [srrw_pkg::KIND_W-1:0]  kind_o,
  output logic [srrw_pkg::SEQ_W-1:0]   ack_seq_o,
  output logic [srrw_pkg::LEN_W-1:0]   out_length_o,
  output logic [srrw_pkg::TAG_W-1:0]   out_tag_o,
  output logic [srrw_pkg::FREE_W-1:0]  free_slots_o,
  output logic                         last_of_run_o
);

  srrw_pkg::cmd_t    cmd;
  srrw_pkg::status_t status;

  srrw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .opcode_i(opcode_i),
    .status_i(status),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  srrw_dpath #(
    .WINDOW_SLOTS(WINDOW_SLOTS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .opcode_i     (opcode_i),
    .seq_i        (seq_i),
    .length_i     (length_i),
    .payload_tag_i(payload_tag_i),
    .strobe_o     (strobe_o),
    .kind_o       (kind_o),
    .ack_seq_o    (ack_seq_o),
    .out_length_o (out_length_o),
    .out_tag_o    (out_tag_o),
    .free_slots_o (free_slots_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

// ===== test/tb_selective_repeat_receive_window.sv =====
// Testbench for the selective-repeat receive window: directed and random
// packet, done and close beats, checked against an in-bench window model.
// Depends on srrw_pkg and selective_repeat_receive_window.
module tb_selective_repeat_receive_window;

  localparam int W           = srrw_pkg::WINDOW_SLOTS_DEF;
  localparam int OP_W        = srrw_pkg::OP_W;
  localparam int SEQ_W       = srrw_pkg::SEQ_W;
  localparam int BASE_W      = srrw_pkg::BASE_W;
  localparam int LEN_W       = srrw_pkg::LEN_W;
  localparam int TAG_W       = srrw_pkg::TAG_W;
  localparam int KIND_W      = srrw_pkg::KIND_W;
  localparam int FREE_W      = srrw_pkg::FREE_W;
  localparam int ITEMS       = 400;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = W + 8;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  ack_seq;
    logic [LEN_W-1:0]  len;
    logic [TAG_W-1:0]  tag;
    logic [FREE_W-1:0] free;
    logic              last;
  } window_result_t;

  // Tracks the window the block should hold and the results it owes.
  class window_ledger;
    window_result_t    pending_results[$];
    bit                slot_full[W];
    logic [SEQ_W-1:0]  slot_seq[W];
    logic [LEN_W-1:0]  slot_len[W];
    logic [TAG_W-1:0]  slot_tag[W];
    logic [BASE_W-1:0] base;
    bit                final_known;
    logic [SEQ_W-1:0]  final_seq;
    bit                closed;
    int                free_count;
    int                mismatches;

    function new();
      foreach (slot_full[i]) slot_full[i] = 1'b0;
      base        = '0;
      final_known = 1'b0;
      final_seq   = '0;
      closed      = 1'b0;
      free_count  = W;
      mismatches  = 0;
    endfunction

    task report(string msg);
      mismatches++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function void push_status(logic [KIND_W-1:0] kind);
      window_result_t r;
      r.kind    = kind;
      r.ack_seq = '0;
      r.len     = '0;
      r.tag     = '0;
      r.free    = FREE_W'(free_count);
      r.last    = 1'b1;
      pending_results.push_back(r);
    endfunction

    function void note_input(logic [OP_W-1:0] op, logic [SEQ_W-1:0] seq,
                             logic [LEN_W-1:0] len, logic [TAG_W-1:0] tag);
      window_result_t r;
      int             slot;
      int             idx;
      if (closed) return;
      case (op)
        srrw_pkg::DATA_PACKET: begin
          slot = int'(seq % W);
          if (longint'(seq) >= longint'(base) && longint'(seq) < longint'(base) + W &&
              !slot_full[slot]) begin
            slot_full[slot] = 1'b1;
            slot_seq[slot]  = seq;
            slot_len[slot]  = len;
            slot_tag[slot]  = tag;
            free_count--;
            // Deliver the in-order run that now starts at the base.
            while (slot_full[base % W]) begin
              idx            = int'(base % W);
              slot_full[idx] = 1'b0;
              free_count++;
              r.kind    = srrw_pkg::KIND_DELIVER;
              r.ack_seq = slot_seq[idx];
              r.len     = slot_len[idx];
              r.tag     = slot_tag[idx];
              r.free    = FREE_W'(free_count);
              base++;
              r.last    = !slot_full[base % W];
              pending_results.push_back(r);
            end
          end
        end
        srrw_pkg::DONE_NOTICE: begin
          if (!final_known) begin
            final_known = 1'b1;
            final_seq   = seq;
          end else if (base > 0 && base > {1'b0, final_seq}) begin
            push_status(srrw_pkg::KIND_FINISH);
          end
        end
        srrw_pkg::CLOSE_REQUEST: begin
          closed = 1'b1;
          push_status(srrw_pkg::KIND_CLOSED);
        end
        default: ;
      endcase
    endfunction

    task check_result(window_result_t got);
      window_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d ack_seq %0d", got.kind, got.ack_seq));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind || got.ack_seq !== want.ack_seq ||
          got.len !== want.len || got.tag !== want.tag ||
          got.free !== want.free || got.last !== want.last)
        report($sformatf({"got kind %0d seq %0d len %0d tag %0d free %0d last %0d, ",
                          "expected kind %0d seq %0d len %0d tag %0d free %0d last %0d"},
                         got.kind, got.ack_seq, got.len, got.tag, got.free, got.last,
                         want.kind, want.ack_seq, want.len, want.tag, want.free,
                         want.last));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              start         = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   opcode_i      = '0;
  logic [SEQ_W-1:0]  seq_i         = '0;
  logic [LEN_W-1:0]  length_i      = '0;
  logic [TAG_W-1:0]  payload_tag_i = '0;
  logic              strobe_o;
  logic [KIND_W-1:0] kind_o;
  logic [SEQ_W-1:0]  ack_seq_o;
  logic [LEN_W-1:0]  out_length_o;
  logic [TAG_W-1:0]  out_tag_o;
  logic [FREE_W-1:0] free_slots_o;
  logic              last_of_run_o;

  window_ledger ledger;
  int           quiet_left = 0;

  selective_repeat_receive_window #(
    .WINDOW_SLOTS(W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .seq_i        (seq_i),
    .length_i     (length_i),
    .payload_tag_i(payload_tag_i),
    .strobe_o     (strobe_o),
    .kind_o       (kind_o),
    .ack_seq_o    (ack_seq_o),
    .out_length_o (out_length_o),
    .out_tag_o    (out_tag_o),
    .free_slots_o (free_slots_o),
    .last_of_run_o(last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [LEN_W-1:0] rand16();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return LEN_W'($urandom);
    endcase
  endfunction

  // Mostly random gaps, with occasional stretches of back-to-back beats.
  function automatic int draw_gap();
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) quiet_left = $urandom_range(5, 30);
    return $urandom_range(0, 9);
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, logic [SEQ_W-1:0] seq,
                           logic [LEN_W-1:0] len, logic [TAG_W-1:0] tag);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    opcode_i      <= op;
    seq_i         <= seq;
    length_i      <= len;
    payload_tag_i <= tag;
    do @(posedge clk_i); while (busy);
    ledger.note_input(op, seq, len, tag);
  endtask

  task automatic send_data(logic [SEQ_W-1:0] seq);
    send_item(srrw_pkg::DATA_PACKET, seq, rand16(), rand16());
  endtask

  // Result monitor: a strobe is sampled at the edge that ends its cycle.
  initial begin : result_monitor
    window_result_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && strobe_o) begin
        got.kind    = kind_o;
        got.ack_seq = ack_seq_o;
        got.len     = out_length_o;
        got.tag     = out_tag_o;
        got.free    = free_slots_o;
        got.last    = last_of_run_o;
        ledger.check_result(got);
      end
    end
  end

  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || strobe_o) stall = 0;
      else stall++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int               item_count;
    int               draw;
    int               burst_len;
    int               span;
    int               pick;
    int               tmp;
    int               i;
    int               offsets[W];
    logic [SEQ_W-1:0] base_now;
    ledger = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: ignored opcode, early done notices, window edges,
    // out-of-order fill, below-window and occupied-slot drops.
    send_item(OP_UNUSED, '1, '1, '1);
    send_item(srrw_pkg::DONE_NOTICE, 31'd40, '0, '0);
    send_item(srrw_pkg::DONE_NOTICE, '1, '1, '1);
    send_item(srrw_pkg::DATA_PACKET, '1, '1, '1);
    send_data(SEQ_W'(W));
    send_item(srrw_pkg::DATA_PACKET, SEQ_W'(W - 1), '0, '0);
    send_data(31'd3);
    send_data(31'd1);
    send_data(31'd2);
    send_item(srrw_pkg::DATA_PACKET, 31'd0, '1, '0);
    send_data(31'd2);
    send_data(31'd6);
    send_data(31'd6);
    send_data(31'd5);
    send_data(31'd4);
    send_item(srrw_pkg::DONE_NOTICE, '0, '0, '0);
    send_item(srrw_pkg::DATA_PACKET, 31'd7, '0, '1);
    send_data(SEQ_W'(8 + W - 2));
    send_data(SEQ_W'(8 + W - 1));
    send_data(SEQ_W'(8 + W));

    // Random part: mostly in-window traffic near the base, with bursts that
    // fill the window out of order before closing the gap at the base.
    item_count = 0;
    while (item_count < ITEMS) begin
      draw     = $urandom_range(0, 99);
      base_now = ledger.base[SEQ_W-1:0];
      if (draw < 48) begin
        send_data(SEQ_W'(base_now + $urandom_range(0, 7)));
        item_count++;
      end else if (draw < 62) begin
        send_data(SEQ_W'(base_now + $urandom_range(0, W - 1)));
        item_count++;
      end else if (draw < 68 && base_now > 0) begin
        span = (base_now > 40) ? 40 : int'(base_now) - 1;
        send_data(SEQ_W'(base_now - 1 - $urandom_range(0, span)));
        item_count++;
      end else if (draw < 74) begin
        send_data(SEQ_W'(base_now + W + $urandom_range(0, 100)));
        item_count++;
      end else if (draw < 80) begin
        send_data(SEQ_W'($urandom));
        item_count++;
      end else if (draw < 87) begin
        send_item(srrw_pkg::DONE_NOTICE,
                  SEQ_W'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 60)),
                  rand16(), rand16());
        item_count++;
      end else if (draw < 91) begin
        send_item(OP_UNUSED, SEQ_W'($urandom), rand16(), rand16());
      end else begin
        burst_len = $urandom_range(2, W);
        for (i = 0; i < burst_len - 1; i++) offsets[i] = i + 1;
        for (i = burst_len - 2; i > 0; i--) begin
          pick          = $urandom_range(0, i);
          tmp           = offsets[i];
          offsets[i]    = offsets[pick];
          offsets[pick] = tmp;
        end
        for (i = 0; i < burst_len - 1; i++) send_data(SEQ_W'(base_now + offsets[i]));
        send_data(base_now);
        item_count += burst_len;
      end
    end

    // Close the transfer; every beat after it must be ignored.
    send_item(srrw_pkg::CLOSE_REQUEST, SEQ_W'($urandom), rand16(), rand16());
    send_data(ledger.base[SEQ_W-1:0]);
    send_item(srrw_pkg::DONE_NOTICE, '0, '0, '0);
    send_item(srrw_pkg::CLOSE_REQUEST, '0, '0, '0);
    send_item(OP_UNUSED, '0, '0, '0);
    start <= 1'b0;

    while (ledger.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (ledger.mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
